// ===== hdl/circular_queue_with_negative_purge_assert.svh =====
// ---------------------------------------------------------------------------
// circular queue with negative purge: assertion macros
// shared assertion wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_NEGATIVE_PURGE_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_NEGATIVE_PURGE_ASSERT_SVH

// clocked assertion, off while reset is high
`define CQNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CQNP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cqnp_pkg.sv =====
// ---------------------------------------------------------------------------
// cqnp_pkg
// types and constants shared by the queue, its cells and its checker
// ---------------------------------------------------------------------------
package cqnp_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CAP_W     = 5;
  localparam int COUNT_W   = 5;
  localparam int CAP_RESET = 16;

  typedef enum logic [1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_PURGE = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_PURGE
  } state_t;

  typedef struct packed {
    action_t                  action;
    logic signed [WORD_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     done_ok;
    logic signed [WORD_W-1:0] head_value;
    logic                     head_valid;
    logic [COUNT_W-1:0]       fill_count;
    logic                     is_full;
    logic                     is_empty;
  } result_t;

  typedef struct packed {
    logic shift;
    logic load_head;
    logic load_in;
  } cell_ctl_t;

endpackage

// ===== hdl/cqnp_cell.sv =====
// ---------------------------------------------------------------------------
// cqnp_cell
// one queue slot: loads a new word, the recycled head word or its neighbour
// ---------------------------------------------------------------------------
module cqnp_cell (
  input  logic                            clk,
  input  cqnp_pkg::cell_ctl_t             ctl,
  input  logic [cqnp_pkg::WORD_W-1:0]     in_word,
  input  logic [cqnp_pkg::WORD_W-1:0]     head_word,
  input  logic [cqnp_pkg::WORD_W-1:0]     right_word,
  output logic [cqnp_pkg::WORD_W-1:0]     word
);

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      word <= in_word;
    end else if (ctl.load_head) begin
      word <= head_word;
    end else if (ctl.shift) begin
      word <= right_word;
    end
  end

endmodule

// ===== hdl/circular_queue_with_negative_purge.sv =====
// ---------------------------------------------------------------------------
// circular_queue_with_negative_purge
// FIFO of signed words held as a row of cells, head in cell 0
// ---------------------------------------------------------------------------
// Usage:
//   An item (action, value) is taken at a clock edge with start high and
//   busy low. One result beat follows for every item, on result with strobe
//   high for exactly one cycle; the receiver cannot stall it.
//   Enqueue, dequeue and the unused action code: result in the cycle after
//   the item is taken, and a new item may be taken in every cycle.
//   Purge: the cells rotate once per held word, with busy high while they
//   rotate, and the result comes in the cycle after the last rotation (an
//   empty queue does not rotate). Each rotation step moves the head word
//   to the tail if it is not negative and drops it otherwise.
//   Capacity is written on cfg_data with cfg_valid, taken when cfg_ready is
//   high (whenever no purge runs); a write empties the queue.
//   Reset (rst, synchronous) empties the queue, sets the capacity to 16
//   (or DEPTH if smaller) and drops any pending result beat.
// ---------------------------------------------------------------------------
module circular_queue_with_negative_purge #(
  parameter int DEPTH = cqnp_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  cqnp_pkg::item_t             item,
  output logic                        strobe,
  output cqnp_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cqnp_pkg::CAP_W-1:0]  cfg_data
);

  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = cqnp_pkg::COUNT_W;
  localparam int WORD_W    = cqnp_pkg::WORD_W;
  localparam int CAP_INIT  = (cqnp_pkg::CAP_RESET > DEPTH) ? DEPTH : cqnp_pkg::CAP_RESET;

  cqnp_pkg::state_t    state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    steps, steps_next;
  logic [CNT_W-1:0]    eff_cap, eff_cap_next;
  logic                strobe_next;
  logic [WORD_W-1:0]   popped, popped_next;
  logic                ok, ok_next;
  logic [CNT_W-1:0]    cap_new;

  logic                accept;
  logic                shift_all;
  logic                load_head;
  logic                load_in;

  logic [WORD_W-1:0]   word [DEPTH];
  cqnp_pkg::cell_ctl_t ctl  [DEPTH];

  assign accept    = start && !busy;
  assign busy      = (state != cqnp_pkg::ST_IDLE);
  assign cfg_ready = (state == cqnp_pkg::ST_IDLE);

  // clamp the written capacity into 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cap_new = CNT_W'(1);
    end else if (int'(cfg_data) > DEPTH) begin
      cap_new = CNT_W'(DEPTH);
    end else begin
      cap_new = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cqnp_pkg::ST_IDLE;
      count   <= '0;
      steps   <= '0;
      eff_cap <= CNT_W'(CAP_INIT);
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      steps   <= steps_next;
      eff_cap <= eff_cap_next;
      strobe  <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    popped <= popped_next;
    ok     <= ok_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    steps_next   = steps;
    eff_cap_next = eff_cap;
    strobe_next  = 1'b0;
    popped_next  = popped;
    ok_next      = ok;
    shift_all    = 1'b0;
    load_head    = 1'b0;
    load_in      = 1'b0;
    case (state)
      cqnp_pkg::ST_IDLE: begin
        if (accept) begin
          popped_next = '0;
          ok_next     = 1'b0;
          strobe_next = 1'b1;
          case (item.action)
            cqnp_pkg::ACT_ENQ: begin
              if (count < eff_cap) begin
                load_in    = 1'b1;
                count_next = count + 1'b1;
                ok_next    = 1'b1;
              end
            end
            cqnp_pkg::ACT_DEQ: begin
              if (count != '0) begin
                shift_all   = 1'b1;
                popped_next = word[0];
                count_next  = count - 1'b1;
                ok_next     = 1'b1;
              end
            end
            cqnp_pkg::ACT_PURGE: begin
              if (count != '0) begin
                state_next  = cqnp_pkg::ST_PURGE;
                steps_next  = count;
                strobe_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        if (cfg_valid) begin
          eff_cap_next = cap_new;
          count_next   = '0;
        end
      end
      cqnp_pkg::ST_PURGE: begin
        // rotate: head word goes to the tail unless it is negative
        shift_all = 1'b1;
        if (!word[0][WORD_W-1]) begin
          load_head = 1'b1;
        end else begin
          count_next = count - 1'b1;
        end
        steps_next = steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          state_next  = cqnp_pkg::ST_IDLE;
          strobe_next = 1'b1;
        end
      end
      default: begin
        state_next = cqnp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].shift     = shift_all;
      ctl[i].load_head = load_head && (count - 1'b1 == CNT_W'(i));
      ctl[i].load_in   = load_in && (count == CNT_W'(i));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] right;
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = word[g+1];
    end
    cqnp_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .in_word    (item.value),
      .head_word  (word[0]),
      .right_word (right),
      .word       (word[g])
    );
  end

  assign result.popped_value = popped;
  assign result.done_ok      = ok;
  assign result.head_value   = (count != '0) ? word[0] : '0;
  assign result.head_valid   = (count != '0);
  assign result.fill_count   = OUT_CNT_W'(count);
  assign result.is_full      = (count == eff_cap);
  assign result.is_empty     = (count == '0);

endmodule

// ===== hdl/cqnp_checker.sv =====
// ---------------------------------------------------------------------------
// cqnp_checker
// port-level checks on the queue, bound to the top level
// ---------------------------------------------------------------------------
`include "circular_queue_with_negative_purge_assert.svh"

module cqnp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input cqnp_pkg::item_t            item,
  input logic                       strobe,
  input cqnp_pkg::result_t          result
);

  logic quick_take;
  logic flags_ok;
  logic no_pop;

  assign quick_take = start && !busy && (item.action != cqnp_pkg::ACT_PURGE);
  assign flags_ok   = (result.head_valid != result.is_empty) &&
                      !(result.is_full && result.is_empty);
  assign no_pop     = strobe && !result.done_ok;

  `CQNP_ASSERT(a_quick_beat, quick_take |=> strobe, "no result beat after a quick item")
  `CQNP_ASSERT(a_no_beat_busy, busy |-> !strobe, "result beat during a purge")
  `CQNP_ASSERT(a_flags, strobe |-> flags_ok, "inconsistent status flags")
  `CQNP_ASSERT(a_popped_zero, no_pop |-> (result.popped_value == '0), "stray popped word")
  `CQNP_ASSERT_RST(a_reset, rst |=> (!busy && !strobe), "queue active after reset")

endmodule

bind circular_queue_with_negative_purge cqnp_checker u_cqnp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);
